// ----- design/grt_pkg.sv -----
package grt_pkg;

   // Longest string the offsets can describe; offsets saturate at the
   // smaller of this and the largest 16-bit value.
   localparam logic [31:0] MAX_LENGTH = 32'd65535;
   localparam logic [15:0] POS_CAP =
      (MAX_LENGTH < 32'd65535) ? MAX_LENGTH[15:0] : 16'hFFFF;

   localparam int CHAR_WIDTH = 8;
   localparam int OFFSET_WIDTH = 16;
   localparam int KIND_WIDTH = 2;

   // Room for the results of one byte, and the depth of the queue of bundles.
   localparam int MAX_RESULTS = 3;
   localparam int COUNT_WIDTH = $clog2(MAX_RESULTS + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // Lexer modes.
   localparam logic [2:0] MODE_BETWEEN = 3'd0;
   localparam logic [2:0] MODE_IDENT = 3'd1;
   localparam logic [2:0] MODE_QUOTE = 3'd2;
   localparam logic [2:0] MODE_MINUS = 3'd3;
   localparam logic [2:0] MODE_HALTED = 3'd4;

   // Token kinds.
   localparam logic [KIND_WIDTH-1:0] KIND_IDENT = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_TERMINAL = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_ARROW = 2'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_END = 2'd3;

   localparam logic [CHAR_WIDTH-1:0] CHAR_QUOTE = 8'h27;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_GREATER = 8'h3E;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UNDERSCORE = 8'h5F;

   typedef struct packed {
      logic [KIND_WIDTH-1:0]   token_kind;
      logic [OFFSET_WIDTH-1:0] start_offset;
      logic [OFFSET_WIDTH-1:0] end_offset;
      logic                    halted_early;
      logic                    last_result;
   } result_type;

   // All results caused by one request, in order from index zero.
   typedef struct packed {
      logic [COUNT_WIDTH-1:0]           count;
      result_type [MAX_RESULTS-1:0]     results;
   } bundle_type;

   function automatic logic is_space_byte(input logic [CHAR_WIDTH-1:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_letter_byte(input logic [CHAR_WIDTH-1:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_id_byte(input logic [CHAR_WIDTH-1:0] c);
      return is_letter_byte(c) || (c >= 8'h30 && c <= 8'h39) || (c == CHAR_UNDERSCORE);
   endfunction

   function automatic result_type make_result(
      input logic [KIND_WIDTH-1:0]   kind,
      input logic [OFFSET_WIDTH-1:0] start_off,
      input logic [OFFSET_WIDTH-1:0] end_off,
      input logic                    halted,
      input logic                    last
   );
      result_type r;
      r.token_kind = kind;
      r.start_offset = start_off;
      r.end_offset = end_off;
      r.halted_early = halted;
      r.last_result = last;
      return r;
   endfunction

endpackage

// ----- design/grt_req_if.sv -----
interface grt_req_if;
   logic                               valid;
   logic                               ready;
   logic [grt_pkg::CHAR_WIDTH-1:0]     char_byte;
   logic                               last_byte;

   modport source (output valid, output char_byte, output last_byte, input ready);
   modport sink (input valid, input char_byte, input last_byte, output ready);
endinterface

// ----- design/grt_rsp_if.sv -----
interface grt_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [grt_pkg::KIND_WIDTH-1:0]     token_kind;
   logic [grt_pkg::OFFSET_WIDTH-1:0]   start_offset;
   logic [grt_pkg::OFFSET_WIDTH-1:0]   end_offset;
   logic                               halted_early;
   logic                               last_result;

   modport source (output valid, output token_kind, output start_offset,
                   output end_offset, output halted_early, output last_result,
                   input ready);
   modport sink (input valid, input token_kind, input start_offset,
                 input end_offset, input halted_early, input last_result,
                 output ready);
endinterface

// ----- design/grt_front.sv -----
module grt_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [grt_pkg::CHAR_WIDTH-1:0]   char_byte,
   input  logic                             last_byte,
   output logic                             push,
   output grt_pkg::bundle_type              push_bundle
);
   import grt_pkg::*;

   logic [2:0]              mode_ff, mode_in;
   logic [OFFSET_WIDTH-1:0] pos_ff, pos_in;
   logic [OFFSET_WIDTH-1:0] begin_ff, begin_in;
   logic [OFFSET_WIDTH-1:0] halt_ff, halt_in;
   logic [OFFSET_WIDTH-1:0] pos_next;
   bundle_type              bundle;

   // Offset of the byte after this one, held at the bound.
   assign pos_next = (pos_ff == POS_CAP) ? pos_ff : pos_ff + 16'd1;

   // Lexer step: update the mode and gather the results of this request.
   always_comb begin
      logic [2:0]              md;
      logic [OFFSET_WIDTH-1:0] bg;
      logic [OFFSET_WIDTH-1:0] ht;
      logic [COUNT_WIDTH-1:0]  n;
      md = mode_ff;
      bg = begin_ff;
      ht = halt_ff;
      n = '0;
      bundle = '0;

      // A byte that cannot continue an identifier closes it first.
      if (md == MODE_IDENT && !is_id_byte(char_byte)) begin
         bundle.results[n] = make_result(KIND_IDENT, bg, pos_ff, 1'b0, 1'b0);
         n = n + 2'd1;
         md = MODE_BETWEEN;
      end

      case (md)
         MODE_BETWEEN: begin
            if (is_space_byte(char_byte)) begin
               md = MODE_BETWEEN;
            end else if (is_letter_byte(char_byte)) begin
               md = MODE_IDENT;
               bg = pos_ff;
            end else if (char_byte == CHAR_QUOTE) begin
               md = MODE_QUOTE;
               bg = pos_ff;
            end else if (char_byte == CHAR_MINUS) begin
               md = MODE_MINUS;
               bg = pos_ff;
            end else begin
               md = MODE_HALTED;
               ht = pos_ff;
            end
         end
         MODE_QUOTE: begin
            if (char_byte == CHAR_QUOTE) begin
               bundle.results[n] = make_result(KIND_TERMINAL, bg, pos_next, 1'b0, 1'b0);
               n = n + 2'd1;
               md = MODE_BETWEEN;
            end
         end
         MODE_MINUS: begin
            if (char_byte == CHAR_GREATER) begin
               bundle.results[n] = make_result(KIND_ARROW, bg, pos_next, 1'b0, 1'b0);
               n = n + 2'd1;
               md = MODE_BETWEEN;
            end else begin
               md = MODE_HALTED;
               ht = bg;
            end
         end
         default: begin
            md = md;
         end
      endcase

      // The final byte closes an open identifier, halts an open quote or minus, and adds the end record.
      if (last_byte) begin
         if (md == MODE_IDENT) begin
            bundle.results[n] = make_result(KIND_IDENT, bg, pos_next, 1'b0, 1'b0);
            n = n + 2'd1;
            md = MODE_BETWEEN;
         end else if (md == MODE_QUOTE || md == MODE_MINUS) begin
            md = MODE_HALTED;
            ht = bg;
         end
         if (md == MODE_HALTED) begin
            bundle.results[n] = make_result(KIND_END, ht, pos_next, 1'b1, 1'b1);
         end else begin
            bundle.results[n] = make_result(KIND_END, pos_next, pos_next, 1'b0, 1'b1);
         end
         n = n + 2'd1;
         mode_in = MODE_BETWEEN;
         pos_in = '0;
         begin_in = '0;
         halt_in = '0;
      end else begin
         mode_in = md;
         pos_in = pos_next;
         begin_in = bg;
         halt_in = ht;
      end
      bundle.count = n;
   end

   assign push = accept && (bundle.count != '0);
   assign push_bundle = bundle;

   // Lexer state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_BETWEEN;
         pos_ff <= '0;
         begin_ff <= '0;
         halt_ff <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         pos_ff <= pos_in;
         begin_ff <= begin_in;
         halt_ff <= halt_in;
      end
   end

endmodule

// ----- design/grt_queue.sv -----
module grt_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  grt_pkg::bundle_type  push_bundle,
   input  logic                 pop,
   output logic                 not_full,
   output logic                 not_empty,
   output grt_pkg::bundle_type  head_bundle
);
   import grt_pkg::*;

   bundle_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0] count_ff, count_in;

   assign not_full = (count_ff != QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_bundle = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Bundle storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_bundle;
      end
   end

endmodule

// ----- design/grt_back.sv -----
module grt_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  grt_pkg::bundle_type  head_bundle,
   output logic                 pop,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output grt_pkg::result_type  rsp_result
);
   import grt_pkg::*;

   logic [COUNT_WIDTH-1:0] idx_ff, idx_in;
   logic                   valid_ff, valid_in;
   result_type             result_ff;
   logic                   load;
   logic                   last_of_bundle;

   // The output register takes the next result when empty or being drained.
   assign load = head_valid && (!valid_ff || rsp_ready);
   assign last_of_bundle = (idx_ff == head_bundle.count - 1'b1);
   assign pop = load && last_of_bundle;

   always_comb begin
      idx_in = idx_ff;
      if (load) begin
         idx_in = last_of_bundle ? '0 : idx_ff + 1'b1;
      end
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= head_bundle.results[idx_ff[1:0]];
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_result = result_ff;

endmodule

// ----- design/grammar_rule_tokenizer_unit.sv -----
// The lexer writes the bundle of each request into the queue; its results then go through the
// output register to the response channel. Throughput: one request per cycle while the queue
// has room; results leave one per cycle while the receiver is ready, so a request causing several
// (at most two) holds the response side until all are out. A queue of four bundles absorbs this.
// Reset is synchronous and active high; it clears the lexer state, the queue and the output.
module grammar_rule_tokenizer_unit (
   input logic        clock,
   input logic        reset,
   grt_req_if.sink    req_ch,
   grt_rsp_if.source  rsp_ch
);
   import grt_pkg::*;

   logic       accept;
   logic       push;
   bundle_type push_bundle;
   logic       pop;
   logic       not_full;
   logic       not_empty;
   bundle_type head_bundle;
   result_type rsp_result;

   // A request is taken whenever the queue has room for its bundle.
   assign req_ch.ready = not_full;
   assign accept = req_ch.valid && not_full;

   grt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .char_byte   (req_ch.char_byte),
      .last_byte   (req_ch.last_byte),
      .push        (push),
      .push_bundle (push_bundle)
   );

   grt_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .pop         (pop),
      .not_full    (not_full),
      .not_empty   (not_empty),
      .head_bundle (head_bundle)
   );

   grt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (not_empty),
      .head_bundle (head_bundle),
      .pop         (pop),
      .rsp_ready   (rsp_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .rsp_result  (rsp_result)
   );

   assign rsp_ch.token_kind = rsp_result.token_kind;
   assign rsp_ch.start_offset = rsp_result.start_offset;
   assign rsp_ch.end_offset = rsp_result.end_offset;
   assign rsp_ch.halted_early = rsp_result.halted_early;
   assign rsp_ch.last_result = rsp_result.last_result;

endmodule

// ----- test/tb_top.sv -----
module tb_top;
   import grt_pkg::*;

   // One row of the directed table: a request, and where the result can be read off
   // at a glance, the single result it must cause.
   typedef struct packed {
      logic [CHAR_WIDTH-1:0] char_byte;
      logic                  last_byte;
      logic                  typed;
      result_type            want;
   } stim_row_type;

   logic clock;
   logic reset;

   grt_req_if req_bus ();
   grt_rsp_if rsp_bus ();

   grammar_rule_tokenizer_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   stim_row_type stim_table [0:24];

   // Tokens still owed by the block, oldest first, and those lexed from the latest request.
   result_type expected_tokens [$];
   result_type step_tokens [$];
   logic [CHAR_WIDTH-1:0] rule_bytes [$];

   // Shadow lexer state.
   logic [2:0]              lexer_mode;
   logic [OFFSET_WIDTH-1:0] lexer_pos;
   logic [OFFSET_WIDTH-1:0] lexer_begin;
   logic [OFFSET_WIDTH-1:0] lexer_halt;

   int failures;
   int requests_sent;
   int strings_sent;
   int results_seen;
   bit calm;

   // Free-running clock, period 12.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic logic is_blank(input logic [CHAR_WIDTH-1:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_alpha(input logic [CHAR_WIDTH-1:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_word(input logic [CHAR_WIDTH-1:0] c);
      return is_alpha(c) || (c >= 8'h30 && c <= 8'h39) || c == CHAR_UNDERSCORE;
   endfunction

   function automatic logic [CHAR_WIDTH-1:0] blank_byte();
      int r;
      r = $urandom_range(0, 5);
      return (r == 5) ? 8'h20 : 8'h09 + r[7:0];
   endfunction

   function automatic logic [CHAR_WIDTH-1:0] alpha_byte();
      int r;
      r = $urandom_range(0, 51);
      return (r < 26) ? 8'h41 + r[7:0] : 8'h61 + r[7:0] - 8'd26;
   endfunction

   function automatic logic [CHAR_WIDTH-1:0] word_byte();
      int r;
      r = $urandom_range(0, 62);
      if (r < 52) begin
         return alpha_byte();
      end
      return (r < 62) ? 8'h30 + r[7:0] - 8'd52 : CHAR_UNDERSCORE;
   endfunction

   // Any byte but a quote, for the inside of a terminal.
   function automatic logic [CHAR_WIDTH-1:0] quoted_byte();
      logic [CHAR_WIDTH-1:0] b;
      b = 8'($urandom_range(0, 255));
      return (b == CHAR_QUOTE) ? 8'hA7 : b;
   endfunction

   // Readable form of one result for mismatch reports.
   function automatic string result_text(input result_type r);
      return $sformatf("kind %0d start %0d end %0d halted %0d last %0d",
                       r.token_kind, r.start_offset, r.end_offset,
                       r.halted_early, r.last_result);
   endfunction

   task automatic clear_lexer();
      lexer_mode = MODE_BETWEEN;
      lexer_pos = '0;
      lexer_begin = '0;
      lexer_halt = '0;
   endtask

   // Advance the shadow lexer by one byte, leaving the tokens it causes in step_tokens.
   task automatic lex_byte(input logic [CHAR_WIDTH-1:0] c, input logic fin);
      logic [OFFSET_WIDTH-1:0] p;
      logic [OFFSET_WIDTH-1:0] nxt;
      p = lexer_pos;
      nxt = (p >= POS_CAP) ? POS_CAP : p + 16'd1;
      step_tokens.delete();

      // A byte that cannot continue an identifier closes it and is then lexed afresh.
      if (lexer_mode == MODE_IDENT && !is_word(c)) begin
         step_tokens.push_back(result_type'{KIND_IDENT, lexer_begin, p, 1'b0, 1'b0});
         lexer_mode = MODE_BETWEEN;
      end

      case (lexer_mode)
         MODE_BETWEEN: begin
            if (is_blank(c)) begin
               lexer_mode = MODE_BETWEEN;
            end else if (is_alpha(c)) begin
               lexer_mode = MODE_IDENT;
               lexer_begin = p;
            end else if (c == CHAR_QUOTE) begin
               lexer_mode = MODE_QUOTE;
               lexer_begin = p;
            end else if (c == CHAR_MINUS) begin
               lexer_mode = MODE_MINUS;
               lexer_begin = p;
            end else begin
               lexer_mode = MODE_HALTED;
               lexer_halt = p;
            end
         end
         MODE_QUOTE: begin
            if (c == CHAR_QUOTE) begin
               step_tokens.push_back(result_type'{KIND_TERMINAL, lexer_begin, nxt, 1'b0, 1'b0});
               lexer_mode = MODE_BETWEEN;
            end
         end
         MODE_MINUS: begin
            if (c == CHAR_GREATER) begin
               step_tokens.push_back(result_type'{KIND_ARROW, lexer_begin, nxt, 1'b0, 1'b0});
               lexer_mode = MODE_BETWEEN;
            end else begin
               lexer_mode = MODE_HALTED;
               lexer_halt = lexer_begin;
            end
         end
         default: begin
         end
      endcase

      if (!fin) begin
         lexer_pos = nxt;
      end else begin
         // The final byte closes an open identifier; an open quote or minus halts.
         if (lexer_mode == MODE_IDENT) begin
            step_tokens.push_back(result_type'{KIND_IDENT, lexer_begin, nxt, 1'b0, 1'b0});
            lexer_mode = MODE_BETWEEN;
         end else if (lexer_mode == MODE_QUOTE || lexer_mode == MODE_MINUS) begin
            lexer_mode = MODE_HALTED;
            lexer_halt = lexer_begin;
         end
         if (lexer_mode == MODE_HALTED) begin
            step_tokens.push_back(result_type'{KIND_END, lexer_halt, nxt, 1'b1, 1'b1});
         end else begin
            step_tokens.push_back(result_type'{KIND_END, nxt, nxt, 1'b0, 1'b1});
         end
         clear_lexer();
      end
   endtask

   // Offer one request, possibly after an idle burst, and record what it must cause.
   task automatic send_request(input logic [CHAR_WIDTH-1:0] c, input logic fin,
                               input logic typed, input result_type want);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.char_byte <= c;
      req_bus.last_byte <= fin;
      @(negedge clock);
      while (!req_bus.ready) @(negedge clock);
      // The request is taken at the coming rising edge.
      lex_byte(c, fin);
      if (typed) begin
         expected_tokens.push_back(want);
      end else begin
         foreach (step_tokens[k]) expected_tokens.push_back(step_tokens[k]);
      end
      requests_sent++;
      if (fin) begin
         strings_sent++;
      end
      @(posedge clock);
   endtask

   task automatic send_rule();
      int k;
      for (k = 0; k < rule_bytes.size(); k++) begin
         send_request(rule_bytes[k], k == rule_bytes.size() - 1, 1'b0, '0);
      end
   endtask

   // Hold the request side off until every owed token has come back.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_tokens.size() != 0) @(posedge clock);
   endtask

   // A rule of well-formed tokens with random content, now and then spoilt by noise.
   task automatic build_random_rule();
      int ntok;
      int t;
      int k;
      int len;
      int kind;
      bit prev_ident;
      logic [CHAR_WIDTH-1:0] b;
      rule_bytes.delete();
      ntok = $urandom_range(1, 6);
      prev_ident = 1'b0;
      for (t = 0; t < ntok; t++) begin
         kind = $urandom_range(0, 8);
         if (kind <= 3) begin
            if (prev_ident || $urandom_range(0, 2) == 0) begin
               rule_bytes.push_back(blank_byte());
            end
            rule_bytes.push_back(alpha_byte());
            len = $urandom_range(0, 4);
            for (k = 0; k < len; k++) rule_bytes.push_back(word_byte());
            prev_ident = 1'b1;
         end else begin
            if ($urandom_range(0, 2) == 0) begin
               rule_bytes.push_back(blank_byte());
            end
            if (kind <= 5) begin
               rule_bytes.push_back(CHAR_QUOTE);
               len = $urandom_range(0, 3);
               for (k = 0; k < len; k++) rule_bytes.push_back(quoted_byte());
               rule_bytes.push_back(CHAR_QUOTE);
            end else if (kind <= 7) begin
               rule_bytes.push_back(CHAR_MINUS);
               rule_bytes.push_back(CHAR_GREATER);
            end else begin
               len = $urandom_range(1, 3);
               for (k = 0; k < len; k++) rule_bytes.push_back(blank_byte());
            end
            prev_ident = 1'b0;
         end
      end

      // Noise: a stray byte, an unclosed quote, or a minus with no arrow head.
      case ($urandom_range(0, 9))
         0: begin
            b = 8'($urandom_range(0, 255));
            rule_bytes.insert($urandom_range(0, rule_bytes.size()), b);
         end
         1: begin
            rule_bytes.push_back(CHAR_QUOTE);
            len = $urandom_range(0, 2);
            for (k = 0; k < len; k++) rule_bytes.push_back(quoted_byte());
         end
         2: begin
            rule_bytes.push_back(CHAR_MINUS);
         end
         3: begin
            b = 8'($urandom_range(0, 255));
            rule_bytes.push_back(CHAR_MINUS);
            rule_bytes.push_back((b == CHAR_GREATER) ? 8'h3F : b);
            rule_bytes.push_back(alpha_byte());
         end
         default: begin
         end
      endcase
   endtask

   // The receiver stalls in random bursts until the quiet last part of the run.
   initial begin
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Each result taken at the coming edge is compared with the oldest owed token.
   always @(negedge clock) begin : result_check
      result_type want;
      result_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = result_type'{rsp_bus.token_kind, rsp_bus.start_offset, rsp_bus.end_offset,
                            rsp_bus.halted_early, rsp_bus.last_result};
         if (expected_tokens.size() == 0) begin
            $display("%0t: result with none owed: %s", $time, result_text(got));
            failures++;
         end else begin
            want = expected_tokens.pop_front();
            results_seen++;
            if (got !== want) begin
               $display("%0t: expected %s, got %s", $time, result_text(want),
                        result_text(got));
               failures++;
            end
         end
      end
   end

   // Overall time limit.
   initial begin
      #(12 * 3000000);
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      int i;
      bit paused;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.char_byte = '0;
      req_bus.last_byte = 1'b0;
      failures = 0;
      requests_sent = 0;
      strings_sent = 0;
      results_seen = 0;
      calm = 1'b0;
      paused = 1'b0;
      clear_lexer();

      // Directed table. Strings of one or two bytes: unmatched zero and high bytes, a lone minus
      // and an unclosed quote halt at offset 0; blanks alone give a clean end record.
      stim_table[0] = '{8'h00, 1'b1, 1'b1, '{KIND_END, 16'd0, 16'd1, 1'b1, 1'b1}};
      stim_table[1] = '{8'hFF, 1'b1, 1'b1, '{KIND_END, 16'd0, 16'd1, 1'b1, 1'b1}};
      stim_table[2] = '{CHAR_MINUS, 1'b1, 1'b1, '{KIND_END, 16'd0, 16'd1, 1'b1, 1'b1}};
      stim_table[3] = '{CHAR_QUOTE, 1'b1, 1'b1, '{KIND_END, 16'd0, 16'd1, 1'b1, 1'b1}};
      stim_table[4] = '{8'h20, 1'b1, 1'b1, '{KIND_END, 16'd1, 16'd1, 1'b0, 1'b1}};
      stim_table[5] = '{8'h0D, 1'b0, 1'b0, '0};
      stim_table[6] = '{8'h0B, 1'b1, 1'b1, '{KIND_END, 16'd2, 16'd2, 1'b0, 1'b1}};
      // "Az->''<tab>q9_'<0x80>'m-x>": adjacent tokens, empty terminal, lone minus.
      stim_table[7] = '{8'h41, 1'b0, 1'b0, '0};
      stim_table[8] = '{8'h7A, 1'b0, 1'b0, '0};
      stim_table[9] = '{CHAR_MINUS, 1'b0, 1'b0, '0};
      stim_table[10] = '{CHAR_GREATER, 1'b0, 1'b0, '0};
      stim_table[11] = '{CHAR_QUOTE, 1'b0, 1'b0, '0};
      stim_table[12] = '{CHAR_QUOTE, 1'b0, 1'b0, '0};
      stim_table[13] = '{8'h09, 1'b0, 1'b0, '0};
      stim_table[14] = '{8'h71, 1'b0, 1'b0, '0};
      stim_table[15] = '{8'h39, 1'b0, 1'b0, '0};
      stim_table[16] = '{CHAR_UNDERSCORE, 1'b0, 1'b0, '0};
      stim_table[17] = '{CHAR_QUOTE, 1'b0, 1'b0, '0};
      stim_table[18] = '{8'h80, 1'b0, 1'b0, '0};
      stim_table[19] = '{CHAR_QUOTE, 1'b0, 1'b0, '0};
      stim_table[20] = '{8'h6D, 1'b0, 1'b0, '0};
      stim_table[21] = '{CHAR_MINUS, 1'b0, 1'b0, '0};
      stim_table[22] = '{8'h78, 1'b0, 1'b0, '0};
      stim_table[23] = '{CHAR_GREATER, 1'b1, 1'b0, '0};
      // An identifier closed by the final byte.
      stim_table[24] = '{8'h5A, 1'b1, 1'b0, '0};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < 25; i++) begin
         send_request(stim_table[i].char_byte, stim_table[i].last_byte,
                      stim_table[i].typed, stim_table[i].want);
      end
      wait_drained();

      // Random rules, with one pause part-way for the block to empty.
      while (requests_sent < 150) begin
         build_random_rule();
         send_rule();
         if (!paused && requests_sent >= 90) begin
            wait_drained();
            paused = 1'b1;
         end
      end

      // Last part: no idling on either side.
      calm = 1'b1;
      while (requests_sent < 205) begin
         build_random_rule();
         send_rule();
      end
      req_bus.valid <= 1'b0;

      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Checked %0d results from %0d requests over %0d rule strings.",
               results_seen, requests_sent, strings_sent);
      $display("Stalls came from both sides, the block was drained once mid-run, "
               , "and the run closed at full rate.");
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/grt_pkg.sv
design/grt_req_if.sv
design/grt_rsp_if.sv
design/grt_front.sv
design/grt_queue.sv
design/grt_back.sv
design/grammar_rule_tokenizer_unit.sv
test/tb_top.sv
